// File: rtl/rsh_pkg.sv
`default_nettype none

package rsh_pkg;

    localparam int DW             = 40;   // internal Q.28 datapath width
    localparam int QF             = 28;   // fraction bits of the datapath
    localparam int VAL_W          = 32;
    localparam int DEG_W          = 3;
    localparam int IDX_W          = 4;
    localparam int PADDR_W        = 2;
    localparam int PDATA_W        = 32;
    localparam int MAX_DEGREE_DEF = 4;
    localparam int TABLE_DEGREE   = 4;
    localparam int DIV_STEPS      = 30;

    localparam logic [PADDR_W-1:0] ADDR_DEGREE = '0;
    localparam logic signed [DW-1:0] QONE = 40'sh00_1000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQ_ISSUE,
        ST_SQ_WAIT,
        ST_SQ_DONE,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_MUL_DONE,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_Z2,
        OP_Z3,
        OP_Z4,
        OP_V0,
        OP_CX,
        OP_SY,
        OP_SX,
        OP_CY,
        OP_G,
        OP_VC,
        OP_VS
    } op_t;

    // Normalization constants K_lm in Q.28.
    function automatic logic signed [DW-1:0] k_coef(input logic [DEG_W-1:0] d,
                                                    input logic [DEG_W-1:0] m);
        logic signed [DW-1:0] k;
        unique case ({d, m})
            6'o00:   k = 40'sd75724244;
            6'o10:   k = 40'sd131158238;
            6'o11:   k = 40'sd131158238;
            6'o20:   k = 40'sd84662279;
            6'o21:   k = 40'sd293278736;
            6'o22:   k = 40'sd146639368;
            6'o30:   k = 40'sd100173759;
            6'o31:   k = 40'sd122687298;
            6'o32:   k = 40'sd387971300;
            6'o33:   k = 40'sd158388620;
            6'o40:   k = 40'sd28396592;
            6'o41:   k = 40'sd179595814;
            6'o42:   k = 40'sd126993418;
            6'o43:   k = 40'sd475165860;
            6'o44:   k = 40'sd167996501;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Legendre polynomial in z, Condon-Shortley sign included.
    function automatic logic signed [DW-1:0] p_val(input logic [DEG_W-1:0] d,
                                                   input logic [DEG_W-1:0] m,
                                                   input logic signed [DW-1:0] z,
                                                   input logic signed [DW-1:0] z2,
                                                   input logic signed [DW-1:0] z3,
                                                   input logic signed [DW-1:0] z4);
        logic signed [DW-1:0] p;
        p = QONE;
        unique case (d)
            3'd1:
            begin
                p = (m == 3'd0) ? z : -QONE;
            end
            3'd2:
            begin
                if (m == 3'd0)
                    p = 40'sd3 * z2 - QONE;
                else if (m == 3'd1)
                    p = -z;
                else
                    p = QONE;
            end
            3'd3:
            begin
                if (m == 3'd0)
                    p = 40'sd5 * z3 - 40'sd3 * z;
                else if (m == 3'd1)
                    p = -(40'sd5 * z2 - QONE);
                else if (m == 3'd2)
                    p = z;
                else
                    p = -QONE;
            end
            3'd4:
            begin
                if (m == 3'd0)
                    p = 40'sd35 * z4 - 40'sd30 * z2 + 40'sd3 * QONE;
                else if (m == 3'd1)
                    p = -(40'sd7 * z3 - 40'sd3 * z);
                else if (m == 3'd2)
                    p = 40'sd7 * z2 - QONE;
                else if (m == 3'd3)
                    p = -z;
                else
                    p = QONE;
            end
            default:
            begin
                p = QONE;
            end
        endcase
        return p;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [DW-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (v < -40'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rsh_in_if.sv
`default_nettype none

interface rsh_in_if import rsh_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] gx;
    logic signed [VAL_W-1:0] gy;
    logic signed [VAL_W-1:0] gz;

    modport source (output valid, output gx, output gy, output gz, input ready);
    modport sink   (input valid, input gx, input gy, input gz, output ready);
endinterface

`default_nettype wire

// File: rtl/rsh_out_if.sv
`default_nettype none

interface rsh_out_if import rsh_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] harmonic_value;
    logic [IDX_W-1:0]        component_index;
    logic                    last_component;

    modport source (output valid, output harmonic_value, output component_index,
                    output last_component, input ready);
    modport sink   (input valid, input harmonic_value, input component_index,
                    input last_component, output ready);
endinterface

`default_nettype wire

// File: rtl/rsh_mul.sv
`default_nettype none

// Shared signed multiplier. The product of a by b is formed in two passes
// through one DW x (DW/2+1) multiplier: the low half of b first, then the
// high half added in shifted; the full product is ready after the second pass.
module rsh_mul import rsh_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic signed [DW-1:0]   a,
    input  wire logic signed [DW-1:0]   b,
    output logic signed [2*DW-1:0]      prod,
    output logic signed [DW-1:0]        qprod
);

    localparam int HW = DW / 2;
    localparam logic signed [2*DW-1:0] RND = (2*DW)'(1) <<< (QF - 1);

    logic                     phase_reg;
    logic signed [DW-1:0]     a_hold_reg;
    logic signed [DW-HW-1:0]  bhi_reg;
    logic signed [2*DW-1:0]   acc_reg;

    logic signed [DW-1:0]     op_a;
    logic signed [HW:0]       op_b;
    logic signed [DW+HW:0]    pp;
    logic signed [2*DW-1:0]   rnd;

    always_comb
    begin
        op_a = phase_reg ? a_hold_reg : a;
        op_b = phase_reg ? {bhi_reg[DW-HW-1], bhi_reg} : {1'b0, b[HW-1:0]};
        pp   = op_a * op_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 1'b0;
        else if (phase_reg)
            phase_reg <= 1'b0;
        else if (start)
            phase_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg)
        begin
            acc_reg <= acc_reg + ((2*DW)'(pp) <<< HW);
        end
        else if (start)
        begin
            acc_reg    <= (2*DW)'(pp);
            a_hold_reg <= a;
            bhi_reg    <= b[DW-1:HW];
        end
    end

    always_comb
    begin
        rnd   = acc_reg + RND;
        prod  = acc_reg;
        qprod = rnd[DW+QF-1:QF];
    end

endmodule

`default_nettype wire

// File: rtl/real_spherical_harmonics_core.sv
// Real spherical harmonics core.
//
// Each item on in_ch is one 3-D vector (gx, gy, gz, Q15.16). For every item
// the core sends 2l+1 items on out_ch: the real spherical harmonics of the
// degree l held in the degree register, in the order m=0, then the cos and
// sin terms for m=1..l, in Q3.28. The last one of a vector has
// last_component set. Degree is written over the APB port at address 0 and
// is clamped to the supported maximum; it should be written while idle.
//
// The core takes one vector at a time. From acceptance it normalizes the
// magnitudes one bit per cycle, forms the sum of squares, takes a
// bit-serial square root and divides each component by the norm one
// quotient bit a cycle. All products go through one shared two-pass
// multiplier; each further m costs 7 products and gives two results. A zero
// vector skips the normalization, sum of squares, square root and
// division. Reset clears the degree to 0 and empties the output register.
// When the receiver stalls, the finished result waits in the output
// register and the sequencer holds until it is taken; a new vector is
// taken once the last result of the previous one is in the output
// register.
`default_nettype none

module real_spherical_harmonics_core import rsh_pkg::*; #(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    rsh_in_if.sink                   in_ch,
    rsh_out_if.source                out_ch,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    // The highest degree the table supports, limited further by the parameter.
    localparam int LIM = (MAX_DEGREE < TABLE_DEGREE) ? MAX_DEGREE : TABLE_DEGREE;
    localparam logic [DEG_W-1:0] LIM_D = DEG_W'(LIM);
    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

    state_t state_reg, state_next;
    op_t    op_reg;

    logic [DEG_W-1:0]       degree_reg;
    logic [DEG_W-1:0]       deg_eff;
    logic [DEG_W-1:0]       m_reg;
    logic [4:0]             cnt_reg;
    logic [1:0]             comp_reg;

    logic                   ovalid_reg;
    logic signed [VAL_W-1:0] oval_reg;
    logic [IDX_W-1:0]       oidx_reg;
    logic                   olast_reg;

    logic [VAL_W-1:0]       mag_reg [3];
    logic                   neg_reg [3];
    logic                   zero_reg;
    logic [63:0]            sum_reg;
    logic [63:0]            res_reg;
    logic [63:0]            bit_reg;
    logic [32:0]            rem_reg;
    logic [DIV_STEPS-1:0]   lo_reg;
    logic [DIV_STEPS-1:0]   q_reg;

    logic signed [DW-1:0]   x_reg, y_reg, z_reg, z2_reg, z3_reg, z4_reg;
    logic signed [DW-1:0]   c_reg, s_reg, cx_reg, sy_reg, sx_reg, g_reg, v_reg;

    logic [VAL_W-1:0]       in_mag [3];
    logic                   in_zero;
    logic                   norm_ok;
    logic                   out_free;
    logic                   emit_op;
    logic                   emit_last;
    logic [63:0]            trial;
    logic                   root_ge;
    logic [32:0]            divisor;
    logic [33:0]            div_t;
    logic                   div_ge;
    logic [DIV_STEPS-1:0]   q_final;
    logic signed [DW-1:0]   unit_val;
    logic [61:0]            num;

    logic                   mul_start;
    logic signed [DW-1:0]   mul_a, mul_b;
    logic signed [2*DW-1:0] mul_prod;
    logic signed [DW-1:0]   mul_q;

    logic signed [VAL_W-1:0] emit_val;
    logic [IDX_W-1:0]        emit_idx;

    rsh_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .qprod (mul_q)
    );

    // Configuration port.
    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_DEGREE) ? PDATA_W'(degree_reg) : '0;
    assign deg_eff = (degree_reg > LIM_D) ? LIM_D : degree_reg;

    // Status used by the sequencer.
    always_comb
    begin
        in_mag[0] = mag_of(in_ch.gx);
        in_mag[1] = mag_of(in_ch.gy);
        in_mag[2] = mag_of(in_ch.gz);
        in_zero   = (in_mag[0] == '0) && (in_mag[1] == '0) && (in_mag[2] == '0);
        norm_ok   = |{mag_reg[0][31:30], mag_reg[1][31:30], mag_reg[2][31:30]};
        out_free  = !ovalid_reg || out_ch.ready;
        emit_op   = (op_reg == OP_V0) || (op_reg == OP_VC) || (op_reg == OP_VS);
        emit_last = ((op_reg == OP_V0) && (deg_eff == '0)) ||
                    ((op_reg == OP_VS) && (m_reg == deg_eff));

        // Square root: one result bit per cycle.
        trial   = res_reg + bit_reg;
        root_ge = (sum_reg >= trial);

        // Division of (mag << 29) + r by 2r, one quotient bit per cycle.
        num      = 62'({mag_reg[comp_reg], 29'd0}) + 62'(res_reg[31:0]);
        divisor  = {res_reg[31:0], 1'b0};
        div_t    = {rem_reg, lo_reg[DIV_STEPS-1]};
        div_ge   = (div_t >= 34'(divisor));
        q_final  = {q_reg[DIV_STEPS-2:0], div_ge};
        unit_val = neg_reg[comp_reg] ? -DW'(q_final) : DW'(q_final);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                    state_next = in_zero ? ST_MUL_ISSUE : ST_NORM;
            end
            ST_NORM:
            begin
                if (norm_ok)
                    state_next = ST_SQ_ISSUE;
            end
            ST_SQ_ISSUE: state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:  state_next = ST_SQ_DONE;
            ST_SQ_DONE:  state_next = (cnt_reg == 5'd2) ? ST_SQRT : ST_SQ_ISSUE;
            ST_SQRT:
            begin
                if (bit_reg[0])
                    state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = (comp_reg == 2'd2) ? ST_MUL_ISSUE : ST_DIV_INIT;
            end
            ST_MUL_ISSUE: state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:  state_next = ST_MUL_DONE;
            ST_MUL_DONE:  state_next = emit_op ? ST_EMIT : ST_MUL_ISSUE;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = emit_last ? ST_IDLE : ST_MUL_ISSUE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: multiplier operands and the result item.
    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        mul_start   = (state_reg == ST_MUL_ISSUE) || (state_reg == ST_SQ_ISSUE);
        mul_a       = DW'(mag_reg[cnt_reg[1:0]]);
        mul_b       = DW'(mag_reg[cnt_reg[1:0]]);
        if (state_reg == ST_MUL_ISSUE)
        begin
            unique case (op_reg)
                OP_Z2: begin mul_a = z_reg;  mul_b = z_reg;  end
                OP_Z3: begin mul_a = z2_reg; mul_b = z_reg;  end
                OP_Z4: begin mul_a = z2_reg; mul_b = z2_reg; end
                OP_V0:
                begin
                    mul_a = k_coef(deg_eff, '0);
                    mul_b = p_val(deg_eff, '0, z_reg, z2_reg, z3_reg, z4_reg);
                end
                OP_CX: begin mul_a = c_reg;  mul_b = x_reg;  end
                OP_SY: begin mul_a = s_reg;  mul_b = y_reg;  end
                OP_SX: begin mul_a = s_reg;  mul_b = x_reg;  end
                OP_CY: begin mul_a = c_reg;  mul_b = y_reg;  end
                OP_G:
                begin
                    mul_a = k_coef(deg_eff, m_reg);
                    mul_b = p_val(deg_eff, m_reg, z_reg, z2_reg, z3_reg, z4_reg);
                end
                OP_VC: begin mul_a = g_reg;  mul_b = c_reg;  end
                OP_VS: begin mul_a = g_reg;  mul_b = s_reg;  end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end

        // A zero vector gives only the constant term for degree 0.
        emit_val = (zero_reg && (deg_eff != '0)) ? '0 : sat_val(v_reg);
        if (op_reg == OP_V0)
            emit_idx = '0;
        else if (op_reg == OP_VC)
            emit_idx = IDX_W'({m_reg, 1'b0}) - IDX_W'(1);
        else
            emit_idx = IDX_W'({m_reg, 1'b0});

        out_ch.valid           = ovalid_reg;
        out_ch.harmonic_value  = oval_reg;
        out_ch.component_index = oidx_reg;
        out_ch.last_component  = olast_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            degree_reg <= '0;
            ovalid_reg <= 1'b0;
            op_reg     <= OP_Z2;
            m_reg      <= '0;
            cnt_reg    <= '0;
            comp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && (paddr == ADDR_DEGREE))
                degree_reg <= pwdata[DEG_W-1:0];

            if ((state_reg == ST_EMIT) && out_free)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    op_reg  <= OP_Z2;
                    cnt_reg <= '0;
                    m_reg   <= '0;
                end
                ST_SQ_DONE:  cnt_reg <= cnt_reg + 5'd1;
                ST_SQRT:     comp_reg <= '0;
                ST_DIV_INIT: cnt_reg <= '0;
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if ((cnt_reg == DIV_LAST) && (comp_reg != 2'd2))
                        comp_reg <= comp_reg + 2'd1;
                end
                ST_MUL_DONE:
                begin
                    unique case (op_reg)
                        OP_Z2:   op_reg <= OP_Z3;
                        OP_Z3:   op_reg <= OP_Z4;
                        OP_Z4:   op_reg <= OP_V0;
                        OP_CX:   op_reg <= OP_SY;
                        OP_SY:   op_reg <= OP_SX;
                        OP_SX:   op_reg <= OP_CY;
                        OP_CY:   op_reg <= OP_G;
                        OP_G:    op_reg <= OP_VC;
                        default: op_reg <= op_reg;
                    endcase
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        if (op_reg == OP_V0)
                        begin
                            m_reg  <= DEG_W'(1);
                            op_reg <= OP_CX;
                        end
                        else if (op_reg == OP_VC)
                        begin
                            op_reg <= OP_VS;
                        end
                        else
                        begin
                            m_reg  <= m_reg + DEG_W'(1);
                            op_reg <= OP_CX;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= in_mag[i];
                end
                neg_reg[0] <= in_ch.gx[VAL_W-1];
                neg_reg[1] <= in_ch.gy[VAL_W-1];
                neg_reg[2] <= in_ch.gz[VAL_W-1];
                zero_reg   <= in_zero;
                sum_reg    <= '0;
                x_reg      <= '0;
                y_reg      <= '0;
                z_reg      <= '0;
                c_reg      <= QONE;
                s_reg      <= '0;
            end
            ST_NORM:
            begin
                if (!norm_ok)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= {mag_reg[i][VAL_W-2:0], 1'b0};
                    end
                end
            end
            ST_SQ_DONE:
            begin
                sum_reg <= sum_reg + mul_prod[63:0];
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            ST_SQRT:
            begin
                if (root_ge)
                begin
                    sum_reg <= sum_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            ST_DIV_INIT:
            begin
                rem_reg <= {1'b0, num[61:30]};
                lo_reg  <= num[DIV_STEPS-1:0];
                q_reg   <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? 33'(div_t - 34'(divisor)) : div_t[32:0];
                lo_reg  <= {lo_reg[DIV_STEPS-2:0], 1'b0};
                q_reg   <= q_final;
                if (cnt_reg == DIV_LAST)
                begin
                    if (comp_reg == 2'd0)
                        x_reg <= unit_val;
                    else if (comp_reg == 2'd1)
                        y_reg <= unit_val;
                    else
                        z_reg <= unit_val;
                end
            end
            ST_MUL_DONE:
            begin
                unique case (op_reg)
                    OP_Z2: z2_reg <= mul_q;
                    OP_Z3: z3_reg <= mul_q;
                    OP_Z4: z4_reg <= mul_q;
                    OP_CX: cx_reg <= mul_q;
                    OP_SY: sy_reg <= mul_q;
                    OP_SX: sx_reg <= mul_q;
                    OP_CY:
                    begin
                        c_reg <= cx_reg - sy_reg;
                        s_reg <= sx_reg + mul_q;
                    end
                    OP_G:  g_reg <= mul_q;
                    OP_V0, OP_VC, OP_VS: v_reg <= mul_q;
                    default: ;
                endcase
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    oval_reg  <= emit_val;
                    oidx_reg  <= emit_idx;
                    olast_reg <= emit_last;
                end
            end
            default: ;
        endcase
    end

    // Loading the last result of a vector returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && emit_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the last result");

    // The norm of a normalized vector lies in [2^30, 2^32).
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_INIT) |-> (res_reg[31:30] != 2'b00 && res_reg[63:32] == '0))
        else $error("square root out of its expected range");

    // No harmonic beyond the effective degree is ever emitted.
    a_m_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (m_reg <= deg_eff))
        else $error("order index exceeds the degree");

    // An accepted vector keeps the input closed on the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input opened while a vector is in progress");

endmodule

`default_nettype wire
